// ===== hw/rtl/text_console_writer_unit_macros.svh =====
// assertion macros for the text console writer
// used by the top level only, expects clk and arst_n in scope
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// shared types, constants and helpers for the text console writer
// no dependencies
package tcw_pkg;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 32;
	localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(CELL_COUNT);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int DIV_BIT_W   = $clog2(COL_W);
	localparam int PADDR_W     = 4;

	localparam logic [7:0] COLS_MAX = 8'(MAX_COLUMNS);
	localparam logic [5:0] ROWS_MAX = 6'(MAX_ROWS);

	localparam logic [7:0] COLUMNS_RST = 8'd80;
	localparam logic [5:0] ROWS_RST    = 6'd25;
	localparam logic [7:0] ATTR_RST    = 8'h1F;
	localparam logic [7:0] TAB_RST     = 8'd8;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_ATTR    = 2'd2;
	localparam logic [1:0] REG_TAB     = 2'd3;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_MOVE  = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MUL_CURSOR,
		MUL_TARGET,
		MUL_AREA
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_BS_DEC,
		ST_CELL,
		ST_DIV,
		ST_TAB_ADD,
		ST_WRAP,
		ST_AREA,
		ST_SWEEP_PREP,
		ST_SWEEP,
		ST_RD_ISSUE,
		ST_OFFSET,
		ST_FINISH
	} state_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] char_code;
		logic [6:0] target_col;
		logic [4:0] target_row;
	} tcw_req_t;

	typedef struct packed {
		logic [11:0] cursor_offset;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [7:0]  read_char;
		logic [7:0]  read_attr;
		logic        scrolled;
	} tcw_rsp_t;

	typedef struct packed {
		logic     start;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_init;
		logic     div_step;
		logic     tab_add;
		logic     bs_dec;
		logic     cell_write;
		logic     new_line;
		logic     move;
		logic     sweep_prep;
		logic     sweep_step;
		logic     read_issue;
		logic     out_load;
	} tcw_cmd_t;

	typedef struct packed {
		action_t act;
		logic    is_newline;
		logic    is_tab;
		logic    is_bs;
		logic    x_zero;
		logic    need_nl;
		logic    nl_scroll;
		logic    div_last;
		logic    sweep_done;
	} tcw_stat_t;

	function automatic logic [7:0] eff_cols(input logic [7:0] c);
		if (c == 8'd0) begin
			return 8'd1;
		end
		return (c > COLS_MAX) ? COLS_MAX : c;
	endfunction

	function automatic logic [5:0] eff_rows(input logic [5:0] r);
		if (r == 6'd0) begin
			return 6'd1;
		end
		return (r > ROWS_MAX) ? ROWS_MAX : r;
	endfunction

	function automatic logic [7:0] eff_tab(input logic [7:0] t, input logic [7:0] cols);
		logic [7:0] v;
		v = (t == 8'd0) ? 8'd1 : t;
		return (v > cols) ? cols : v;
	endfunction

endpackage

// ===== hw/rtl/tcw_channels.sv =====
// valid/ready channels for request and response items
// depends on tcw_pkg
interface tcw_req_if;
	import tcw_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_code;
	logic [6:0] target_col;
	logic [4:0] target_row;

	modport source(output valid, action, char_code, target_col, target_row, input ready);
	modport sink(input valid, action, char_code, target_col, target_row, output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;
	logic        valid;
	logic        ready;
	logic [11:0] cursor_offset;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [7:0]  read_char;
	logic [7:0]  read_attr;
	logic        scrolled;

	modport source(output valid, cursor_offset, cursor_col, cursor_row, read_char, read_attr,
		scrolled, input ready);
	modport sink(input valid, cursor_offset, cursor_col, cursor_row, read_char, read_attr,
		scrolled, output ready);
endinterface

// ===== hw/rtl/tcw_datapath.sv =====
// cursor, screen memory, multiplier, tab divider and sweep counters
// depends on tcw_pkg, driven by tcw_ctrl
module tcw_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  tcw_pkg::tcw_cmd_t  cmd,
	output tcw_pkg::tcw_stat_t stat,
	input  tcw_pkg::tcw_req_t  req_item,
	input  logic [7:0]       cols_eff,
	input  logic [5:0]       rows_eff,
	input  logic [7:0]       tab_cfg,
	input  logic [7:0]       attr,
	output tcw_pkg::tcw_rsp_t  rsp_item
);
	import tcw_pkg::*;

	// cursor and flags
	logic [7:0]           x_q;
	logic [ROW_W-1:0]     y_q;
	logic                 scr_q;
	logic                 rd_q;
	logic                 pend_v_q;
	// latched item and geometry
	action_t              act_q;
	logic [7:0]           ch_q;
	logic [COL_W-1:0]     tx_q;
	logic [ROW_W-1:0]     ty_q;
	logic [7:0]           cols_q;
	logic [5:0]           rows_q;
	logic [7:0]           tw_q;
	// arithmetic and sweep
	logic [ADDR_W:0]      prod_q;
	logic [COL_W-1:0]     rem_q;
	logic [DIV_BIT_W-1:0] bit_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     area_q;
	logic [CNT_W-1:0]     copy_q;
	logic [ADDR_W-1:0]    pend_q;
	tcw_rsp_t             res_q;
	// memory
	logic [15:0]          mem [CELL_COUNT];
	logic [15:0]          rdata_q;

	logic [5:0]           mul_b;
	logic [7:0]           shifted;
	logic [15:0]          blank;
	logic                 we;
	logic                 re;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic [15:0]          wdata;
	logic [ADDR_W-1:0]    cell_addr;
	logic                 sweep_issue;

	assign blank     = {attr, 8'h00};
	assign cell_addr = prod_q[ADDR_W-1:0] + ADDR_W'(x_q[COL_W-1:0]);
	assign shifted   = {rem_q, x_q[bit_q]};
	assign sweep_issue = cmd.sweep_step && (cnt_q < area_q);

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_CURSOR: mul_b = 6'(y_q);
			MUL_TARGET: mul_b = 6'(ty_q);
			MUL_AREA:   mul_b = rows_q;
			default:    mul_b = 6'(y_q);
		endcase
	end

	always_comb begin
		we    = pend_v_q | cmd.cell_write;
		waddr = pend_v_q ? pend_q : cell_addr;
		if (pend_v_q) begin
			wdata = (CNT_W'(pend_q) < copy_q) ? rdata_q : blank;
		end else begin
			wdata = stat.is_bs ? blank : {attr, ch_q};
		end
		re    = cmd.read_issue | sweep_issue;
		raddr = cmd.read_issue ? (prod_q[ADDR_W-1:0] + ADDR_W'(tx_q))
			: ADDR_W'(cnt_q + CNT_W'(cols_q));
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// status
	always_comb begin
		stat.act        = act_q;
		stat.is_newline = (ch_q == CH_LF) || (ch_q == CH_CR);
		stat.is_tab     = (ch_q == CH_TAB);
		stat.is_bs      = (ch_q == CH_BS);
		stat.x_zero     = (x_q == 8'd0);
		stat.need_nl    = ((act_q == ACT_PUT) && stat.is_newline) || (x_q >= cols_q);
		stat.nl_scroll  = (6'(y_q) + 6'd1) >= rows_q;
		stat.div_last   = (bit_q == '0);
		stat.sweep_done = (cnt_q == area_q) && !pend_v_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			scr_q    <= 1'b0;
			rd_q     <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				// pull a cursor left outside by a geometry change back on screen
				x_q   <= (x_q >= cols_eff) ? cols_eff - 8'd1 : x_q;
				y_q   <= (6'(y_q) >= rows_eff) ? ROW_W'(rows_eff - 6'd1) : y_q;
				scr_q <= 1'b0;
				rd_q  <= 1'b0;
			end
			if (cmd.move) begin
				x_q <= 8'(tx_q);
				y_q <= ty_q;
			end
			if (cmd.bs_dec) begin
				x_q <= x_q - 8'd1;
			end
			if (cmd.cell_write && !stat.is_bs) begin
				x_q <= x_q + 8'd1;
			end
			if (cmd.tab_add) begin
				x_q <= x_q + tw_q - 8'(rem_q);
			end
			if (cmd.new_line) begin
				x_q <= (x_q >= cols_q) ? x_q - cols_q : 8'd0;
				if (stat.nl_scroll) begin
					y_q   <= ROW_W'(rows_q - 6'd1);
					scr_q <= 1'b1;
				end else begin
					y_q <= y_q + ROW_W'(1);
				end
			end
			if (cmd.sweep_prep) begin
				pend_v_q <= 1'b0;
				if (act_q == ACT_CLEAR) begin
					x_q <= '0;
					y_q <= '0;
				end
			end
			if (cmd.sweep_step) begin
				pend_v_q <= sweep_issue;
			end
			if (cmd.read_issue) begin
				rd_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q  <= req_item.action;
			ch_q   <= req_item.char_code;
			tx_q   <= (8'(req_item.target_col) >= cols_eff) ? COL_W'(cols_eff - 8'd1)
				: req_item.target_col;
			ty_q   <= (6'(req_item.target_row) >= rows_eff) ? ROW_W'(rows_eff - 6'd1)
				: req_item.target_row;
			cols_q <= cols_eff;
			rows_q <= rows_eff;
			tw_q   <= eff_tab(tab_cfg, cols_eff);
		end
		if (cmd.mul_en) begin
			prod_q <= (ADDR_W + 1)'(14'(cols_q) * 14'(mul_b));
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			bit_q <= DIV_BIT_W'(COL_W - 1);
		end
		if (cmd.div_step) begin
			// one restoring step of x mod tab width
			rem_q <= (shifted >= tw_q) ? COL_W'(shifted - tw_q) : COL_W'(shifted);
			bit_q <= bit_q - DIV_BIT_W'(1);
		end
		if (cmd.sweep_prep) begin
			area_q <= prod_q;
			copy_q <= scr_q ? prod_q - CNT_W'(cols_q) : '0;
			cnt_q  <= '0;
		end
		if (sweep_issue) begin
			pend_q <= cnt_q[ADDR_W-1:0];
			cnt_q  <= cnt_q + CNT_W'(1);
		end
		if (cmd.out_load) begin
			res_q.cursor_offset <= prod_q[ADDR_W-1:0] + ADDR_W'(x_q[COL_W-1:0]);
			res_q.cursor_col    <= x_q[COL_W-1:0];
			res_q.cursor_row    <= y_q;
			res_q.read_char     <= rd_q ? rdata_q[7:0] : 8'd0;
			res_q.read_attr     <= rd_q ? rdata_q[15:8] : 8'd0;
			res_q.scrolled      <= scr_q;
		end
	end

	assign rsp_item = res_q;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// sequencer for the text console writer: one item at a time
// depends on tcw_pkg, drives tcw_datapath
module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_cmd_t  cmd
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   load;

	assign load      = (state_q == ST_FINISH) && (!out_valid_q || rsp_ready);
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (stat.act)
					ACT_PUT: begin
						if (stat.is_newline) begin
							state_d = ST_WRAP;
						end else if (stat.is_tab) begin
							state_d = ST_DIV;
						end else if (stat.is_bs) begin
							state_d = stat.x_zero ? ST_WRAP : ST_BS_DEC;
						end else begin
							state_d = ST_CELL;
						end
					end
					ACT_CLEAR: state_d = ST_SWEEP_PREP;
					ACT_MOVE:  state_d = ST_OFFSET;
					ACT_READ:  state_d = ST_RD_ISSUE;
					default:   state_d = ST_OFFSET;
				endcase
			end
			ST_BS_DEC:  state_d = ST_CELL;
			ST_CELL:    state_d = ST_WRAP;
			ST_DIV: begin
				if (stat.div_last) state_d = ST_TAB_ADD;
			end
			ST_TAB_ADD: state_d = ST_WRAP;
			ST_WRAP: begin
				state_d = (stat.need_nl && stat.nl_scroll) ? ST_AREA : ST_OFFSET;
			end
			ST_AREA:       state_d = ST_SWEEP_PREP;
			ST_SWEEP_PREP: state_d = ST_SWEEP;
			ST_SWEEP: begin
				if (stat.sweep_done) state_d = ST_OFFSET;
			end
			ST_RD_ISSUE: state_d = ST_OFFSET;
			ST_OFFSET:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_CURSOR;
		unique case (state_q)
			ST_IDLE: cmd.start = req_valid;
			ST_DECODE: begin
				cmd.mul_en = 1'b1;
				unique case (stat.act)
					ACT_READ:  cmd.mul_sel = MUL_TARGET;
					ACT_CLEAR: cmd.mul_sel = MUL_AREA;
					default:   cmd.mul_sel = MUL_CURSOR;
				endcase
				cmd.div_init = (stat.act == ACT_PUT) && stat.is_tab;
				cmd.move     = (stat.act == ACT_MOVE);
			end
			ST_BS_DEC: begin
				cmd.bs_dec = 1'b1;
				cmd.mul_en = 1'b1;
			end
			ST_CELL:       cmd.cell_write = 1'b1;
			ST_DIV:        cmd.div_step = 1'b1;
			ST_TAB_ADD:    cmd.tab_add = 1'b1;
			ST_WRAP:       cmd.new_line = stat.need_nl;
			ST_AREA: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AREA;
			end
			ST_SWEEP_PREP: cmd.sweep_prep = 1'b1;
			ST_SWEEP:      cmd.sweep_step = 1'b1;
			ST_RD_ISSUE:   cmd.read_issue = 1'b1;
			ST_OFFSET:     cmd.mul_en = 1'b1;
			ST_FINISH:     cmd.out_load = load;
			default:       cmd.start = 1'b0;
		endcase
	end

endmodule

// ===== hw/rtl/text_console_writer_unit.sv =====
// Text console writer: owns a screen of up to 128 x 32 character/attribute cells in one
// single-port-write, registered-read memory, plus a cursor. Items are handled one at a time;
// the result register lets the next item start while a result waits. A move goes from
// decode to the offset step and a read issues its memory read first. A put writes the
// cell, or runs a seven-step remainder for the tab stop if it is a tab; a backspace steps
// back first, but at column zero and for a newline nothing is written. Every put then
// checks for wrap. Clear and scroll sweep the memory, moving or blanking one cell per cycle.
// No clearing pass runs after reset, so the screen contents are undefined until cleared or
// written. Registers on the APB port at byte offsets 0 columns, 4 rows, 8 attribute,
// 12 tab width; write them only while idle.
// depends on tcw_pkg, tcw_channels, tcw_ctrl, tcw_datapath and the macros header
`include "text_console_writer_unit_macros.svh"

module text_console_writer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	tcw_req_if.sink                     req,
	tcw_rsp_if.source                   rsp
);
	import tcw_pkg::*;

	logic [7:0] columns_q;
	logic [5:0] rows_q;
	logic [7:0] attr_q;
	logic [7:0] tab_q;
	logic [7:0] cols_eff;
	logic [5:0] rows_eff;
	logic [1:0] reg_idx;
	tcw_cmd_t   cmd;
	tcw_stat_t  stat;
	tcw_req_t   req_item;
	tcw_rsp_t   rsp_item;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[3:2];
	assign cols_eff = eff_cols(columns_q);
	assign rows_eff = eff_rows(rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RST;
			rows_q    <= ROWS_RST;
			attr_q    <= ATTR_RST;
			tab_q     <= TAB_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_COLUMNS: columns_q <= pwdata[7:0];
				REG_ROWS:    rows_q    <= pwdata[5:0];
				REG_ATTR:    attr_q    <= pwdata[7:0];
				REG_TAB:     tab_q     <= pwdata[7:0];
				default:     columns_q <= columns_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COLUMNS: prdata = 32'(columns_q);
			REG_ROWS:    prdata = 32'(rows_q);
			REG_ATTR:    prdata = 32'(attr_q);
			REG_TAB:     prdata = 32'(tab_q);
			default:     prdata = '0;
		endcase
	end

	assign req_item.action     = action_t'(req.action);
	assign req_item.char_code  = req.char_code;
	assign req_item.target_col = req.target_col;
	assign req_item.target_row = req.target_row;

	assign rsp.cursor_offset = rsp_item.cursor_offset;
	assign rsp.cursor_col    = rsp_item.cursor_col;
	assign rsp.cursor_row    = rsp_item.cursor_row;
	assign rsp.read_char     = rsp_item.read_char;
	assign rsp.read_attr     = rsp_item.read_attr;
	assign rsp.scrolled      = rsp_item.scrolled;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcw_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_item (req_item),
		.cols_eff (cols_eff),
		.rows_eff (rows_eff),
		.tab_cfg  (tab_q),
		.attr     (attr_q),
		.rsp_item (rsp_item)
	);

	// one item in flight: no second accept straight after the first
	`TCW_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accept while busy")
	`TCW_ASSERT_SAME(a_cursor_on_screen, rsp.valid, (8'(rsp.cursor_col) < cols_eff) && (6'(rsp.cursor_row) < rows_eff), "cursor off screen")
	`TCW_ASSERT_SAME(a_scroll_bottom, rsp.valid && rsp.scrolled, 6'(rsp.cursor_row) == rows_eff - 6'd1, "scroll not on bottom row")
	`TCW_ASSERT_SAME(a_offset_match, rsp.valid, rsp.cursor_offset == 12'(13'(rsp.cursor_row) * 13'(cols_eff) + 13'(rsp.cursor_col)), "offset mismatch")

endmodule
